// ----- design/fvmc_pkg.sv -----
package fvmc_pkg;

  // number of statistics counters and their width
  localparam int NUM_CNT = 7;
  localparam int CNT_W   = 32;

  // result transfer: five flag bits, then the counters, padded to whole bytes
  localparam int FLAG_W  = 5;
  localparam int OUT_W   = ((FLAG_W + NUM_CNT * CNT_W + 7) / 8) * 8;

  // depth of the event queue between front and back
  localparam int QDEPTH  = 4;

  // check algorithm codes, the two top codes act as off
  typedef enum logic [2:0] {
    ALG_OFF, ALG_XOR8, ALG_SUM8, ALG_CRC8, ALG_CRC16, ALG_CRC32, ALG_RSV6, ALG_RSV7
  } check_alg_t;

  // configuration register indexes, the top index is not a register
  typedef enum logic [2:0] {
    REG_HEADER, REG_FOOTER, REG_SIZES, REG_MIN_LEN, REG_MAX_LEN, REG_CHECK, REG_LIMITS,
    REG_NONE
  } reg_idx_t;

  // event handed from the front to the back
  typedef struct packed {
    logic clr;   // clear statistics, no result
    logic perr;
    logic lerr;
    logic cerr;
    logic merr;
  } evt_t;

endpackage

// ----- design/fvmc_queue.sv -----
module fvmc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fvmc_pkg::evt_t  push_evt,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output fvmc_pkg::evt_t  head_evt
);

  localparam int PTR_W = (fvmc_pkg::QDEPTH > 1) ? $clog2(fvmc_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(fvmc_pkg::QDEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(fvmc_pkg::QDEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(fvmc_pkg::QDEPTH);

  fvmc_pkg::evt_t   slot_r [fvmc_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign head_evt  = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // event storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_evt;
    end
  end

  // no write into a full queue, no read from an empty one
  assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("event queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
    else $error("event queue underflow");

endmodule

// ----- design/fvmc_front.sv -----
module fvmc_front #(
  parameter int MAX_FRAME     = 4096,
  parameter int LIMIT_ENTRIES = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  // byte stream
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tlast,
  input  logic            in_tuser,
  // configuration writes
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [41:0]     cfg_data,
  // event queue side
  input  logic            q_full,
  output logic            q_push,
  output fvmc_pkg::evt_t  q_evt
);

  localparam int POS_W = $clog2(MAX_FRAME + 1);
  localparam int CW    = ((POS_W > 13) ? POS_W : 13) + 1;
  localparam logic [CW-1:0] MAXF = CW'(MAX_FRAME);
  // pattern byte counts above this are clamped
  localparam int PATTERN_BYTES = 4;
  localparam logic [2:0] PAT_LIM = 3'((PATTERN_BYTES < 4) ? PATTERN_BYTES : 4);

  // configuration registers
  logic [31:0] hdr_pat_r;
  logic [31:0] ftr_pat_r;
  logic [5:0]  sizes_r;
  logic [12:0] min_len_r;
  logic [12:0] max_len_r;
  logic [18:0] check_r;
  logic [41:0] limits_r;

  // frame state
  logic [POS_W-1:0] pos_r, pos_nxt, pos_u;
  logic             hm_r, hm_nxt, hm_u;
  logic [31:0]      tail_r, tail_nxt, tail_u;
  logic [31:0]      run_r, run_nxt, run_u;
  logic [31:0]      exp_r, exp_nxt, exp_u;
  logic             seen_r [LIMIT_ENTRIES];
  logic             seen_nxt [LIMIT_ENTRIES];
  logic             seen_u [LIMIT_ENTRIES];
  logic             over_r [LIMIT_ENTRIES];
  logic             over_nxt [LIMIT_ENTRIES];
  logic             over_u [LIMIT_ENTRIES];

  logic        accept;
  logic        byte_xfer;
  logic [2:0]  h_cnt, f_cnt, algo, flen;
  logic [1:0]  hsh;
  logic [CW-1:0] idx_w, len_w, off_w, fend_w;
  logic [31:0] start_val, run_base, chk_final, tail_mask;
  logic [20:0] ent;
  logic        active, perr, lerr, cerr, merr;

  function automatic logic [31:0] algo_start(input logic [2:0] a);
    logic [31:0] s;
    s = 32'h0;
    if (a == fvmc_pkg::ALG_CRC16) s = 32'h0000_FFFF;
    if (a == fvmc_pkg::ALG_CRC32) s = 32'hFFFF_FFFF;
    return s;
  endfunction

  // one byte of the selected check, bitwise steps unrolled
  function automatic logic [31:0] algo_update(input logic [2:0] a, input logic [31:0] c,
                                              input logic [7:0] b);
    logic [7:0]  c8;
    logic [15:0] c16;
    logic [31:0] c32;
    logic [31:0] r;
    c8  = c[7:0] ^ b;
    c16 = c[15:0] ^ {8'h00, b};
    c32 = c ^ {24'h0, b};
    for (int j = 0; j < 8; j++) begin
      c8  = c8[7] ? ({c8[6:0], 1'b0} ^ 8'h07) : {c8[6:0], 1'b0};
      c16 = c16[0] ? ((c16 >> 1) ^ 16'hA001) : (c16 >> 1);
      c32 = c32[0] ? ((c32 >> 1) ^ 32'hEDB8_8320) : (c32 >> 1);
    end
    unique case (a)
      fvmc_pkg::ALG_XOR8:  r = {24'h0, c[7:0] ^ b};
      fvmc_pkg::ALG_SUM8:  r = {24'h0, c[7:0] + b};
      fvmc_pkg::ALG_CRC8:  r = {24'h0, c8};
      fvmc_pkg::ALG_CRC16: r = {16'h0, c16};
      fvmc_pkg::ALG_CRC32: r = c32;
      default:             r = c;
    endcase
    return r;
  endfunction

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign byte_xfer = accept && !in_tuser;

  // field decode of the configuration
  always_comb begin
    h_cnt  = (sizes_r[2:0] > PAT_LIM) ? PAT_LIM : sizes_r[2:0];
    f_cnt  = (sizes_r[5:3] > PAT_LIM) ? PAT_LIM : sizes_r[5:3];
    algo   = check_r[2:0];
    flen   = check_r[5:3];
    off_w  = CW'(check_r[18:6]);
    fend_w = off_w + CW'(flen);
    active = (algo == fvmc_pkg::ALG_XOR8) || (algo == fvmc_pkg::ALG_SUM8) ||
             (algo == fvmc_pkg::ALG_CRC8) || (algo == fvmc_pkg::ALG_CRC16) ||
             (algo == fvmc_pkg::ALG_CRC32);
  end

  // per-byte update of the frame state
  always_comb begin
    idx_w     = CW'(pos_r);
    start_val = algo_start(algo);
    run_base  = (pos_r == '0) ? start_val : run_r;
    hsh       = 2'(h_cnt - 3'd1 - 3'(pos_r[1:0]));
    ent       = '0;
    pos_u     = pos_r;
    hm_u      = hm_r;
    run_u     = run_r;
    exp_u     = exp_r;
    tail_u    = tail_r;
    for (int k = 0; k < LIMIT_ENTRIES; k++) begin
      seen_u[k] = seen_r[k];
      over_u[k] = over_r[k];
    end
    if (byte_xfer) begin
      run_u = run_base;
      if (idx_w < MAXF) begin
        if (idx_w < CW'(h_cnt)) begin
          if (8'(hdr_pat_r >> {hsh, 3'b000}) != in_tdata) hm_u = 1'b0;
        end
        if (idx_w < off_w) run_u = algo_update(algo, run_base, in_tdata);
        if (idx_w >= off_w && idx_w < fend_w) exp_u = {exp_r[23:0], in_tdata};
        for (int k = 0; k < LIMIT_ENTRIES; k++) begin
          ent = limits_r[21*k +: 21];
          if (ent[20] && (idx_w == CW'(ent[19:8]))) begin
            seen_u[k] = 1'b1;
            if (in_tdata > ent[7:0]) over_u[k] = 1'b1;
          end
        end
        pos_u = pos_r + 1'b1;
      end
      tail_u = {tail_r[23:0], in_tdata};
    end
  end

  // frame checks on the updated state
  always_comb begin
    len_w = CW'(pos_u);
    unique case (f_cnt)
      3'd0:    tail_mask = 32'h0000_0000;
      3'd1:    tail_mask = 32'h0000_00FF;
      3'd2:    tail_mask = 32'h0000_FFFF;
      3'd3:    tail_mask = 32'h00FF_FFFF;
      default: tail_mask = 32'hFFFF_FFFF;
    endcase
    perr = !hm_u || (len_w < CW'(h_cnt)) || (len_w < CW'(f_cnt));
    if (f_cnt != 3'd0 && len_w >= CW'(f_cnt)) begin
      if ((tail_u & tail_mask) != (ftr_pat_r & tail_mask)) perr = 1'b1;
    end
    lerr      = (len_w < CW'(min_len_r)) || (len_w > CW'(max_len_r));
    chk_final = (algo == fvmc_pkg::ALG_CRC32) ? ~run_u : run_u;
    cerr      = active && ((fend_w > len_w) || (chk_final != exp_u));
    merr      = 1'b0;
    for (int k = 0; k < LIMIT_ENTRIES; k++) begin
      if (limits_r[21*k + 20] && (!seen_u[k] || over_u[k])) merr = 1'b1;
    end
  end

  // frame state returns to its start after the last byte
  always_comb begin
    pos_nxt  = pos_u;
    hm_nxt   = hm_u;
    tail_nxt = tail_u;
    run_nxt  = run_u;
    exp_nxt  = exp_u;
    for (int k = 0; k < LIMIT_ENTRIES; k++) begin
      seen_nxt[k] = seen_u[k];
      over_nxt[k] = over_u[k];
    end
    if (byte_xfer && in_tlast) begin
      pos_nxt  = '0;
      hm_nxt   = 1'b1;
      tail_nxt = '0;
      run_nxt  = start_val;
      exp_nxt  = '0;
      for (int k = 0; k < LIMIT_ENTRIES; k++) begin
        seen_nxt[k] = 1'b0;
        over_nxt[k] = 1'b0;
      end
    end
  end

  // events for the back end: a clear, or the flags of a finished frame
  assign q_push     = accept && (in_tuser || in_tlast);
  assign q_evt.clr  = in_tuser;
  assign q_evt.perr = perr;
  assign q_evt.lerr = lerr;
  assign q_evt.cerr = cerr;
  assign q_evt.merr = merr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      hm_r   <= 1'b1;
      tail_r <= '0;
      run_r  <= '0;
      exp_r  <= '0;
      for (int k = 0; k < LIMIT_ENTRIES; k++) begin
        seen_r[k] <= 1'b0;
        over_r[k] <= 1'b0;
      end
    end else begin
      pos_r  <= pos_nxt;
      hm_r   <= hm_nxt;
      tail_r <= tail_nxt;
      run_r  <= run_nxt;
      exp_r  <= exp_nxt;
      for (int k = 0; k < LIMIT_ENTRIES; k++) begin
        seen_r[k] <= seen_nxt[k];
        over_r[k] <= over_nxt[k];
      end
    end
  end

  // configuration register file, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pat_r <= '0;
      ftr_pat_r <= '0;
      sizes_r   <= '0;
      min_len_r <= '0;
      max_len_r <= 13'd4096;
      check_r   <= '0;
      limits_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fvmc_pkg::REG_HEADER:  hdr_pat_r <= cfg_data[31:0];
        fvmc_pkg::REG_FOOTER:  ftr_pat_r <= cfg_data[31:0];
        fvmc_pkg::REG_SIZES:   sizes_r   <= cfg_data[5:0];
        fvmc_pkg::REG_MIN_LEN: min_len_r <= cfg_data[12:0];
        fvmc_pkg::REG_MAX_LEN: max_len_r <= cfg_data[12:0];
        fvmc_pkg::REG_CHECK:   check_r   <= cfg_data[18:0];
        fvmc_pkg::REG_LIMITS:  limits_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // byte position never passes the saturation point
  assert property (@(posedge clk) disable iff (!rst_n) CW'(pos_r) <= MAXF)
    else $error("byte position beyond maximum frame size");
  // position is back at zero after every last byte
  assert property (@(posedge clk) disable iff (!rst_n)
                   (byte_xfer && in_tlast) |=> (pos_r == '0))
    else $error("frame state not cleared after last byte");

endmodule

// ----- design/fvmc_back.sv -----
module fvmc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  // event queue side
  input  logic                       q_valid,
  input  fvmc_pkg::evt_t             q_evt,
  output logic                       q_pop,
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [fvmc_pkg::OUT_W-1:0] out_tdata
);

  localparam int NC = fvmc_pkg::NUM_CNT;
  localparam int CB = fvmc_pkg::CNT_W;

  // counter slots
  localparam int C_SEEN = 0;
  localparam int C_GOOD = 1;
  localparam int C_BAD  = 2;
  localparam int C_PAT  = 3;
  localparam int C_LEN  = 4;
  localparam int C_CHK  = 5;
  localparam int C_LIM  = 6;

  logic [CB-1:0] cnt_r [NC];
  logic [CB-1:0] cnt_nxt [NC];
  logic [CB-1:0] res_cnt_r [NC];
  logic [fvmc_pkg::FLAG_W-1:0] res_flag_r;
  logic [fvmc_pkg::FLAG_W-1:0] flags;
  logic out_valid_r, out_valid_nxt;
  logic frame_pop, clr_pop, good;

  // a frame result leaves only when the output register is free or draining
  assign q_pop     = q_valid && (q_evt.clr || !out_valid_r || out_tready);
  assign frame_pop = q_pop && !q_evt.clr;
  assign clr_pop   = q_pop && q_evt.clr;
  assign good      = !(q_evt.perr || q_evt.lerr || q_evt.cerr || q_evt.merr);
  assign flags     = {q_evt.merr, q_evt.cerr, q_evt.lerr, q_evt.perr, good};

  // statistics update
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      cnt_nxt[k] = clr_pop ? '0 : cnt_r[k];
    end
    if (frame_pop) begin
      cnt_nxt[C_SEEN] = cnt_r[C_SEEN] + 1'b1;
      if (good) cnt_nxt[C_GOOD] = cnt_r[C_GOOD] + 1'b1;
      else      cnt_nxt[C_BAD]  = cnt_r[C_BAD] + 1'b1;
      if (q_evt.perr) cnt_nxt[C_PAT] = cnt_r[C_PAT] + 1'b1;
      if (q_evt.lerr) cnt_nxt[C_LEN] = cnt_r[C_LEN] + 1'b1;
      if (q_evt.cerr) cnt_nxt[C_CHK] = cnt_r[C_CHK] + 1'b1;
      if (q_evt.merr) cnt_nxt[C_LIM] = cnt_r[C_LIM] + 1'b1;
    end
    out_valid_nxt = frame_pop ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int k = 0; k < NC; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < NC; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  // output register holds the snapshot taken with the frame
  always_ff @(posedge clk) begin
    if (frame_pop) begin
      res_flag_r <= flags;
      for (int k = 0; k < NC; k++) begin
        res_cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  always_comb begin
    out_tdata = '0;
    out_tdata[fvmc_pkg::FLAG_W-1:0] = res_flag_r;
    for (int k = 0; k < NC; k++) begin
      out_tdata[fvmc_pkg::FLAG_W + CB*k +: CB] = res_cnt_r[k];
    end
  end

  assign out_tvalid = out_valid_r;

  // every frame is counted as either good or bad
  assert property (@(posedge clk) disable iff (!rst_n)
                   cnt_r[C_SEEN] == CB'(cnt_r[C_GOOD] + cnt_r[C_BAD]))
    else $error("frame counters out of balance");
  // a new result appears only with a frame event taken from the queue
  assert property (@(posedge clk) disable iff (!rst_n)
                   (!out_valid_r ##1 out_valid_r) |-> $past(frame_pop))
    else $error("result shown without a frame event");

endmodule

// ----- design/frame_validator_multi_crc.sv -----
// Byte-serial frame checker.
// in_*  : one frame byte per transfer; in_tlast marks the last byte of a frame,
//         in_tuser = 1 makes the transfer a statistics clear (data and last ignored).
// out_* : one result per frame, given for the last byte: five flags (valid,
//         pattern, length, check, limit) and seven 32-bit wrapping counters.
// cfg_* : register writes, taken at any edge with cfg_we high, index 0 to 6;
//         write only while no frame result is outstanding.
// Throughput is one byte per cycle while the event queue has room: the check update
// is unrolled over the byte in the front stage, so a new byte can be taken every cycle.
// A result passes the front stage, then the event queue into the counter and
// output register, before it is valid.
// When the receiver stalls, a result waits in the output register and up to four
// further frame or clear events wait in the queue; bytes in the middle of a
// frame keep flowing until the queue is full, then in_tready goes low.
// Reset (rst_n low, synchronous) clears counters, frame state and queue and
// loads register defaults; no pass over storage is needed afterwards.
module frame_validator_multi_crc #(
  parameter int MAX_FRAME     = 4096,
  parameter int LIMIT_ENTRIES = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // data_byte
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,
  input  logic                       in_tlast,
  // action
  input  logic                       in_tuser,
  // frame_valid, pattern_error, length_error, check_error, limit_error,
  // frames_seen, frames_good, frames_bad, pattern_fail_count,
  // length_fail_count, check_fail_count, limit_fail_count
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [fvmc_pkg::OUT_W-1:0] out_tdata,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [41:0]                cfg_data
);

  logic           q_full, q_push, q_pop, q_valid;
  fvmc_pkg::evt_t q_in_evt, q_head_evt;

  fvmc_front #(
    .MAX_FRAME     (MAX_FRAME),
    .LIMIT_ENTRIES (LIMIT_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_evt     (q_in_evt)
  );

  fvmc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_evt  (q_in_evt),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_evt  (q_head_evt)
  );

  fvmc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_evt      (q_head_evt),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- verif/tb_frame_validator_multi_crc.sv -----
module tb_frame_validator_multi_crc;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAME    = 4096;
  localparam int LIMIT_N      = 2;
  localparam int PAT_MAX      = 4;
  localparam int RAND_ITEMS   = 1300;
  localparam int CALM_FROM    = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 2000;

  localparam bit [7:0]  CRC8_POLY  = 8'h07;
  localparam bit [15:0] CRC16_POLY = 16'hA001;
  localparam bit [15:0] CRC16_SEED = 16'hFFFF;
  localparam bit [31:0] CRC32_POLY = 32'hEDB88320;
  localparam bit [31:0] CRC32_SEED = 32'hFFFFFFFF;

  typedef enum int {
    CNT_SEEN, CNT_GOOD, CNT_BAD, CNT_PATTERN, CNT_LENGTH, CNT_CHECK, CNT_LIMIT
  } stat_idx_t;

  typedef enum bit { ACT_BYTE = 1'b0, ACT_CLEAR = 1'b1 } action_t;

  typedef struct {
    bit        valid;
    bit        perr;
    bit        lerr;
    bit        cerr;
    bit        merr;
    bit [31:0] cnt[fvmc_pkg::NUM_CNT];
  } frame_report_t;

  // frame checker prediction and report comparison
  class frame_report_board;
    bit [31:0] hdr_pat;
    bit [31:0] ftr_pat;
    bit [5:0]  pat_sizes;
    bit [12:0] min_len;
    bit [12:0] max_len;
    bit [18:0] chk_setup;
    bit [41:0] lim_cfg;

    int unsigned pos;
    bit          hdr_ok;
    bit [31:0]   tail;
    bit [31:0]   run_chk;
    bit [31:0]   field_val;
    bit          lim_seen[LIMIT_N];
    bit          lim_over[LIMIT_N];
    bit [31:0]   stats[fvmc_pkg::NUM_CNT];

    frame_report_t pending_reports[$];
    int unsigned   fail_count;
    int unsigned   reports_checked;

    string cnt_name[fvmc_pkg::NUM_CNT] = '{"frames_seen", "frames_good", "frames_bad",
                                           "pattern_fail_count", "length_fail_count",
                                           "check_fail_count", "limit_fail_count"};

    function new();
      hdr_pat   = '0;
      ftr_pat   = '0;
      pat_sizes = '0;
      min_len   = '0;
      max_len   = 13'd4096;
      chk_setup = '0;
      lim_cfg   = '0;
      foreach (stats[k]) stats[k] = '0;
      clear_frame();
    endfunction

    function int unsigned pat_count(bit [2:0] c);
      return (c > PAT_MAX) ? PAT_MAX : c;
    endfunction

    function bit [31:0] alg_seed(fvmc_pkg::check_alg_t alg);
      if (alg == fvmc_pkg::ALG_CRC16) return {16'd0, CRC16_SEED};
      if (alg == fvmc_pkg::ALG_CRC32) return CRC32_SEED;
      return '0;
    endfunction

    // one byte of the selected check algorithm
    function bit [31:0] check_update(fvmc_pkg::check_alg_t alg, bit [31:0] c, bit [7:0] b);
      bit [7:0]  c8;
      bit [15:0] c16;
      bit [31:0] c32;
      case (alg)
        fvmc_pkg::ALG_XOR8: return {24'd0, c[7:0] ^ b};
        fvmc_pkg::ALG_SUM8: return {24'd0, c[7:0] + b};
        fvmc_pkg::ALG_CRC8: begin
          c8 = c[7:0] ^ b;
          repeat (8) c8 = c8[7] ? ((c8 << 1) ^ CRC8_POLY) : (c8 << 1);
          return {24'd0, c8};
        end
        fvmc_pkg::ALG_CRC16: begin
          c16 = c[15:0] ^ {8'd0, b};
          repeat (8) c16 = c16[0] ? ((c16 >> 1) ^ CRC16_POLY) : (c16 >> 1);
          return {16'd0, c16};
        end
        fvmc_pkg::ALG_CRC32: begin
          c32 = c ^ {24'd0, b};
          repeat (8) c32 = c32[0] ? ((c32 >> 1) ^ CRC32_POLY) : (c32 >> 1);
          return c32;
        end
        default: return c;
      endcase
    endfunction

    function void clear_frame();
      pos       = 0;
      hdr_ok    = 1'b1;
      tail      = '0;
      run_chk   = alg_seed(fvmc_pkg::check_alg_t'(chk_setup[2:0]));
      field_val = '0;
      foreach (lim_seen[k]) begin
        lim_seen[k] = 1'b0;
        lim_over[k] = 1'b0;
      end
    endfunction

    function void set_reg(fvmc_pkg::reg_idx_t i, bit [41:0] v);
      case (i)
        fvmc_pkg::REG_HEADER:  hdr_pat   = v[31:0];
        fvmc_pkg::REG_FOOTER:  ftr_pat   = v[31:0];
        fvmc_pkg::REG_SIZES:   pat_sizes = v[5:0];
        fvmc_pkg::REG_MIN_LEN: min_len   = v[12:0];
        fvmc_pkg::REG_MAX_LEN: max_len   = v[12:0];
        fvmc_pkg::REG_CHECK:   chk_setup = v[18:0];
        fvmc_pkg::REG_LIMITS:  lim_cfg   = v;
        default: ;
      endcase
    endfunction

    // accepted input transfer: update frame state, queue a report on the last byte
    function void note_input(action_t act, bit [7:0] b, bit lst);
      int unsigned          h, f, off, flen;
      fvmc_pkg::check_alg_t alg;
      bit [20:0]            ent;
      bit [31:0]            c, mask;
      frame_report_t        r;
      if (act == ACT_CLEAR) begin
        foreach (stats[k]) stats[k] = '0;
        return;
      end
      h    = pat_count(pat_sizes[2:0]);
      f    = pat_count(pat_sizes[5:3]);
      alg  = fvmc_pkg::check_alg_t'(chk_setup[2:0]);
      flen = chk_setup[5:3];
      off  = chk_setup[18:6];
      if (pos == 0) run_chk = alg_seed(alg);
      if (pos < MAX_FRAME) begin
        if (pos < h && hdr_pat[8*(h-1-pos) +: 8] != b) hdr_ok = 1'b0;
        if (pos < off) run_chk = check_update(alg, run_chk, b);
        if (pos >= off && pos < off + flen) field_val = {field_val[23:0], b};
        for (int k = 0; k < LIMIT_N; k++) begin
          ent = lim_cfg[21*k +: 21];
          if (ent[20] && pos == ent[19:8]) begin
            lim_seen[k] = 1'b1;
            if (b > ent[7:0]) lim_over[k] = 1'b1;
          end
        end
        pos++;
      end
      tail = {tail[23:0], b};
      if (!lst) return;

      // end of frame: evaluate the four checks
      r.perr = !hdr_ok || pos < h || pos < f;
      if (f > 0 && pos >= f) begin
        mask = (f >= 4) ? 32'hFFFFFFFF : ((32'd1 << (8*f)) - 1);
        if (((tail ^ ftr_pat) & mask) != 0) r.perr = 1'b1;
      end
      r.lerr = pos < min_len || pos > max_len;
      r.cerr = 1'b0;
      if (alg >= fvmc_pkg::ALG_XOR8 && alg <= fvmc_pkg::ALG_CRC32) begin
        if (off + flen > pos) begin
          r.cerr = 1'b1;
        end else begin
          c = run_chk;
          if (alg == fvmc_pkg::ALG_CRC32) c = ~c;
          r.cerr = (c != field_val);
        end
      end
      r.merr = 1'b0;
      for (int k = 0; k < LIMIT_N; k++) begin
        ent = lim_cfg[21*k +: 21];
        if (ent[20] && (!lim_seen[k] || lim_over[k])) r.merr = 1'b1;
      end
      r.valid = !(r.perr || r.lerr || r.cerr || r.merr);

      stats[CNT_SEEN]++;
      if (r.valid) stats[CNT_GOOD]++;
      else stats[CNT_BAD]++;
      if (r.perr) stats[CNT_PATTERN]++;
      if (r.lerr) stats[CNT_LENGTH]++;
      if (r.cerr) stats[CNT_CHECK]++;
      if (r.merr) stats[CNT_LIMIT]++;
      foreach (stats[k]) r.cnt[k] = stats[k];
      pending_reports.push_back(r);
      clear_frame();
    endfunction

    function void compare_field(string name, bit [31:0] exp_v, bit [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        fail_count++;
      end
    endfunction

    // accepted result transfer against the oldest queued report
    function void check_report(bit [fvmc_pkg::OUT_W-1:0] d);
      frame_report_t r;
      if (pending_reports.size() == 0) begin
        $error("result transfer with no frame report pending");
        fail_count++;
        return;
      end
      r = pending_reports.pop_front();
      reports_checked++;
      compare_field("frame_valid", r.valid, d[0]);
      compare_field("pattern_error", r.perr, d[1]);
      compare_field("length_error", r.lerr, d[2]);
      compare_field("check_error", r.cerr, d[3]);
      compare_field("limit_error", r.merr, d[4]);
      for (int k = 0; k < fvmc_pkg::NUM_CNT; k++)
        compare_field(cnt_name[k], r.cnt[k],
                      d[fvmc_pkg::FLAG_W + fvmc_pkg::CNT_W*k +: fvmc_pkg::CNT_W]);
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [7:0]                 in_tdata;
  logic                       in_tlast;
  logic                       in_tuser;
  logic                       out_tvalid;
  logic                       out_tready;
  logic [fvmc_pkg::OUT_W-1:0] out_tdata;
  logic                       cfg_we;
  logic [2:0]                 cfg_index;
  logic [41:0]                cfg_data;

  frame_report_board board;
  int unsigned       items_sent;
  int unsigned       setups_used;
  int unsigned       quiet_cycles;
  int                src_idle_pct;
  int                sink_idle_pct;

  frame_validator_multi_crc dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_report(out_tdata);
  end

  // cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog
  initial begin
    quiet_cycles = 0;
    @(posedge clk);
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // receiver backpressure in bursts
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // one input transfer, with an optional idle burst first
  task automatic send_item(action_t act, bit [7:0] b, bit lst);
    if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= b;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(act, b, lst);
    items_sent++;
  endtask

  // stop sending, let all reports come back, then let the pipeline settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(fvmc_pkg::reg_idx_t i, bit [41:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= i;
    cfg_data  <= v;
    @(posedge clk);
    board.set_reg(i, v);
  endtask

  task automatic write_setup(bit [31:0] hdr, bit [31:0] ftr, bit [5:0] sizes,
                             bit [12:0] mn, bit [12:0] mx, bit [18:0] chk,
                             bit [41:0] lim);
    write_reg(fvmc_pkg::REG_HEADER, {10'd0, hdr});
    write_reg(fvmc_pkg::REG_FOOTER, {10'd0, ftr});
    write_reg(fvmc_pkg::REG_SIZES, {36'd0, sizes});
    write_reg(fvmc_pkg::REG_MIN_LEN, {29'd0, mn});
    write_reg(fvmc_pkg::REG_MAX_LEN, {29'd0, mx});
    write_reg(fvmc_pkg::REG_CHECK, {23'd0, chk});
    write_reg(fvmc_pkg::REG_LIMITS, lim);
    cfg_we <= 1'b0;
    setups_used++;
  endtask

  // build a frame that fits the current setup (if shaped, one byte sometimes corrupted) and send it
  task automatic send_frame(int unsigned len, bit shaped);
    bit [7:0]             fb[];
    int unsigned          h, f, off, flen, p;
    bit [31:0]            c;
    bit [20:0]            ent;
    fvmc_pkg::check_alg_t alg;
    fb = new[len];
    foreach (fb[i]) fb[i] = 8'($urandom);
    if (shaped) begin
      h    = board.pat_count(board.pat_sizes[2:0]);
      f    = board.pat_count(board.pat_sizes[5:3]);
      alg  = fvmc_pkg::check_alg_t'(board.chk_setup[2:0]);
      flen = board.chk_setup[5:3];
      off  = board.chk_setup[18:6];
      for (int i = 0; i < h && i < len; i++) fb[i] = board.hdr_pat[8*(h-1-i) +: 8];
      for (int k = 0; k < LIMIT_N; k++) begin
        ent = board.lim_cfg[21*k +: 21];
        if (ent[20] && ent[19:8] < len) fb[ent[19:8]] = 8'($urandom_range(0, ent[7:0]));
      end
      if (off + flen <= len && off < MAX_FRAME) begin
        c = board.alg_seed(alg);
        for (int i = 0; i < off; i++) c = board.check_update(alg, c, fb[i]);
        if (alg == fvmc_pkg::ALG_CRC32) c = ~c;
        // field is big-endian; only its last four bytes carry the value
        for (int j = 0; j < flen; j++)
          if (flen - 1 - j < 4) fb[off + j] = c[8*(flen-1-j) +: 8];
      end
      for (int j = 0; j < f && j < len; j++) fb[len-1-j] = board.ftr_pat[8*j +: 8];
      if ($urandom_range(0, 4) == 0) begin
        p = $urandom_range(0, len - 1);
        fb[p] = fb[p] ^ 8'($urandom_range(1, 255));
      end
    end
    foreach (fb[i]) begin
      if ($urandom_range(0, 99) == 0) send_item(ACT_CLEAR, 8'($urandom), 1'($urandom));
      send_item(ACT_BYTE, fb[i], i == len - 1);
    end
  endtask

  // one phase under a random setup; the algorithm rotates with the phase number
  task automatic run_random_phase(int phase);
    bit [2:0]             hs, fs, flen;
    fvmc_pkg::check_alg_t alg;
    bit [12:0]            off, mn, mx;
    bit [20:0]            ent[LIMIT_N];
    int unsigned          need, len, frames, r;
    hs  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    fs  = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    alg = fvmc_pkg::check_alg_t'(phase % 8);
    case (alg)
      fvmc_pkg::ALG_CRC16: flen = 3'd2;
      fvmc_pkg::ALG_CRC32: flen = 3'd4;
      default:             flen = 3'd1;
    endcase
    if ($urandom_range(0, 3) == 0) flen = 3'($urandom_range(0, 7));
    off = 13'($urandom_range(0, 12));
    mn  = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 40)) : 13'($urandom_range(0, 4));
    case ($urandom_range(0, 3))
      0:       mx = 13'd4096;
      1:       mx = 13'($urandom_range(0, 8191));
      default: mx = 13'($urandom_range(20, 60));
    endcase
    foreach (ent[k]) begin
      ent[k][20]   = 1'($urandom_range(0, 1));
      ent[k][19:8] = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 24));
      ent[k][7:0]  = 8'($urandom);
    end
    write_setup($urandom, $urandom, {fs, hs}, mn, mx, {off, flen, alg}, {ent[1], ent[0]});

    need = off + flen + board.pat_count(fs);
    if (board.pat_count(hs) > need) need = board.pat_count(hs);
    foreach (ent[k])
      if (ent[k][20] && ent[k][19:8] < 64 && ent[k][19:8] + 1 > need) need = ent[k][19:8] + 1;
    if (need == 0) need = 1;

    frames = $urandom_range(6, 16);
    repeat (frames) begin
      r = $urandom_range(0, 19);
      if (r == 0) len = $urandom_range(100, 300);
      else if (r <= 2) len = $urandom_range(1, need);
      else len = need + $urandom_range(0, 10);
      send_frame(len, $urandom_range(0, 4) != 0);
    end
    wait_drained();
  endtask

  function automatic int pick_idle(bit calm, int mid, int high);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 2);
    return (r == 0) ? 0 : (r == 1) ? mid : high;
  endfunction

  initial begin
    int          phase;
    int unsigned rand_start;
    board         = new();
    items_sent    = 0;
    setups_used   = 0;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    in_tuser  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: data extremes, clear with last set, clear inside a frame
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    send_item(ACT_BYTE, 8'h00, 1'b1);
    send_item(ACT_BYTE, 8'hFF, 1'b1);
    send_item(ACT_CLEAR, 8'hFF, 1'b1);
    send_item(ACT_BYTE, 8'hA5, 1'b0);
    send_item(ACT_CLEAR, 8'h5A, 1'b0);
    send_item(ACT_BYTE, 8'h3C, 1'b1);
    wait_drained();

    // all-ones setup: clamped pattern counts, empty length window, unused algorithm
    write_reg(fvmc_pkg::REG_NONE, 42'({$urandom, $urandom}));
    write_setup(32'hFFFFFFFF, 32'hFFFFFFFF, 6'h3F, 13'h1FFF, 13'h0000, 19'h7FFFF,
                42'h3FFFFFFFFFF);
    send_frame(4, 1'b0);
    send_item(ACT_BYTE, 8'hFF, 1'b0);
    send_item(ACT_BYTE, 8'hFF, 1'b1);
    wait_drained();

    // zero patterns, crc32 over an empty span, then a long field past the frame end and one that just fits
    write_setup(32'h0, 32'h0, 6'h00, 13'h0000, 13'h1FFF,
                {13'd0, 3'd4, fvmc_pkg::ALG_CRC32}, 42'h0);
    send_frame(4, 1'b1);
    wait_drained();
    write_setup(32'h0, 32'h0, 6'h00, 13'h0000, 13'h1FFF,
                {13'd2, 3'd7, fvmc_pkg::ALG_CRC16}, 42'h0);
    send_frame(3, 1'b0);
    wait_drained();
    write_setup(32'h0, 32'h0, 6'h00, 13'h0000, 13'h1FFF,
                {13'd1, 3'd7, fvmc_pkg::ALG_CRC16}, 42'h0);
    send_frame(8, 1'b1);
    wait_drained();

    // random setups and frames, idle-free at the end
    rand_start = items_sent;
    phase      = 0;
    while (items_sent - rand_start < RAND_ITEMS) begin
      src_idle_pct  = pick_idle(items_sent - rand_start >= CALM_FROM, 8, 25);
      sink_idle_pct = pick_idle(items_sent - rand_start >= CALM_FROM, 10, 40);
      run_random_phase(phase);
      phase++;
    end
    wait_drained();

    $display("input transfers: %0d, frame reports checked: %0d, setups: %0d",
             items_sent, board.reports_checked, setups_used);
    if (board.fail_count == 0 && board.pending_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
